/* rtl/hpd_pkg.sv */
package hpd_pkg;

   localparam int NUM_CORES      = 4;
   localparam int CORE_BITS      = $clog2(NUM_CORES);
   localparam int WORDS_PER_CORE = 8;
   localparam int WSEL_BITS      = $clog2(WORDS_PER_CORE);
   localparam int TABLE_DEPTH    = NUM_CORES * WORDS_PER_CORE;
   localparam int TABLE_BITS     = $clog2(TABLE_DEPTH);
   localparam int WORD_BITS      = 24;
   localparam int TOTAL_BITS     = 32;
   localparam int LOAD_BITS      = 7;
   localparam int QM_BITS        = 15;
   localparam int RATE_CNT_BITS  = 4;
   localparam int LIMIT_BITS     = 3;
   localparam int PROD_BITS      = TOTAL_BITS + LOAD_BITS;

   localparam int LOAD_SCALE = 100;
   localparam int QM_SCALE   = 100;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = LIMIT_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEEP_MODE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_AWAKE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_SLEEP = 2'd2;

   // item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   // threshold word slots within one core's row
   localparam logic [WSEL_BITS-1:0] W_UP_LOAD   = 3'd0;
   localparam logic [WSEL_BITS-1:0] W_DOWN_LOAD = 3'd1;
   localparam logic [WSEL_BITS-1:0] W_UP_FREQ   = 3'd2;
   localparam logic [WSEL_BITS-1:0] W_DOWN_FREQ = 3'd3;
   localparam logic [WSEL_BITS-1:0] W_UP_RQ     = 3'd4;
   localparam logic [WSEL_BITS-1:0] W_DOWN_RQ   = 3'd5;
   localparam logic [WSEL_BITS-1:0] W_UP_RATE   = 3'd6;
   localparam logic [WSEL_BITS-1:0] W_DOWN_RATE = 3'd7;

   localparam logic [WORD_BITS-1:0] DEFAULT_WORDS [TABLE_DEPTH] = '{
      24'd60, 24'd0,  24'd1242000, 24'd0,       24'd100, 24'd0,   24'd1, 24'd1,
      24'd65, 24'd30, 24'd1566000, 24'd810000,  24'd200, 24'd100, 24'd2, 24'd4,
      24'd65, 24'd30, 24'd1674000, 24'd918000,  24'd300, 24'd200, 24'd2, 24'd4,
      24'd0,  24'd30, 24'd0,       24'd1026000, 24'd0,   24'd300, 24'd1, 24'd4
   };

   typedef struct packed {
      logic                  cmd;
      logic [CORE_BITS-1:0]  core;
      logic [TOTAL_BITS-1:0] wall_total;
      logic [TOTAL_BITS-1:0] idle_total;
      logic [WORD_BITS-1:0]  clock_khz;
      logic [7:0]            runnable;
      logic                  next_online;
      logic [WSEL_BITS-1:0]  word_select;
      logic [WORD_BITS-1:0]  word_value;
   } req_type;

   typedef struct packed {
      logic                 request_up;
      logic                 request_down;
      logic                 load_valid;
      logic [LOAD_BITS-1:0] load_pct;
      logic [QM_BITS-1:0]   queue_metric;
   } rsp_type;

endpackage

/* rtl/core_hotplug_decider.sv */
// Core hotplug decider. Each request word is either a sample for one core (cumulative
// wall and idle counters, clock rate, runnable count, next-core-online flag) or a write
// of one threshold word into that core's eight-word row. A sample produces one response
// word with the load over the interval since the core's previous sample, the queue
// metric (runnable * 100) and at most one of request_up (bring core+1 online) or
// request_down (take this core offline); a threshold write produces an all-zero
// response word. Every request is assumed to succeed. Items are handled one at a time.
// A sample with nonzero busy time steps through accept, delta, serial reads of the
// eight-word threshold row, the scale multiply, the shift/subtract divider and decide.
// A sample with no busy time, or with idle above wall, skips the divider. A threshold
// write goes from accept straight to decide. The response word turns valid at the
// closing edge of the decide cycle. req_ready is high only while the sequencer is idle;
// a finished response sits in the output register, and the next word is accepted and
// worked on while it waits. A response that is not taken stalls the sequencer in its
// decide cycle. Configuration is written through csr_we / csr_index / csr_wdata and
// takes effect at once; write it only while idle.
module core_hotplug_decider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hpd_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hpd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [hpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import hpd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DECIDE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic                  sleep_mode_ff;
   logic [LIMIT_BITS-1:0] limit_awake_ff;
   logic [LIMIT_BITS-1:0] limit_sleep_ff;

   // per-core state
   logic [TOTAL_BITS-1:0]    prev_wall_ff [NUM_CORES];
   logic [TOTAL_BITS-1:0]    prev_idle_ff [NUM_CORES];
   logic [RATE_CNT_BITS-1:0] up_cnt_ff    [NUM_CORES];
   logic [RATE_CNT_BITS-1:0] down_cnt_ff  [NUM_CORES];
   logic [WORD_BITS-1:0]     table_ff     [TABLE_DEPTH];

   // working registers for the item in flight
   req_type               item_ff;
   logic [TOTAL_BITS-1:0] wd_ff;
   logic [TOTAL_BITS-1:0] id_ff;
   logic [WSEL_BITS-1:0]  fetch_ff;
   logic [WORD_BITS-1:0]  thr_ff [WORDS_PER_CORE];
   logic [PROD_BITS-1:0]  rem_ff;
   logic [LOAD_BITS-1:0]  quo_ff;
   logic [2:0]            div_step_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // handshake
   logic accept_req;
   logic rsp_free;
   logic decide_fire;

   // divider step
   logic [PROD_BITS-1:0] dvs;
   logic                 dvs_fits;

   // decision
   logic [WORD_BITS-1:0]     up_period;
   logic [WORD_BITS-1:0]     down_period;
   logic [RATE_CNT_BITS-1:0] up_eff;
   logic [RATE_CNT_BITS-1:0] down_eff;
   logic                     chk_up;
   logic                     chk_down;
   logic [LIMIT_BITS-1:0]    limit_sel;
   logic [LIMIT_BITS-1:0]    limit;
   logic [LIMIT_BITS-1:0]    next_core;
   logic [QM_BITS-1:0]       qm;
   logic                     load_valid;
   logic                     up_cond;
   logic                     down_cond;
   logic                     fire_up;
   logic                     fire_down;
   logic [RATE_CNT_BITS-1:0] up_new;
   logic [RATE_CNT_BITS-1:0] down_new;
   logic                     up_next_set;
   rsp_type                  result;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept_req  = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign decide_fire = (state_ff == ST_DECIDE) && rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               state_in = (req_data.cmd == CMD_WRITE) ? ST_DECIDE : ST_PREP;
            end
         end
         ST_PREP:  state_in = ST_FETCH;
         ST_FETCH: begin
            if (fetch_ff == WSEL_BITS'(WORDS_PER_CORE - 1)) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            // no division when the busy time is zero or the deltas are inconsistent
            state_in = (wd_ff > id_ff) ? ST_DIV : ST_DECIDE;
         end
         ST_DIV: begin
            if (div_step_ff == 3'd0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_mode_ff  <= 1'b0;
         limit_awake_ff <= LIMIT_BITS'(NUM_CORES);
         limit_sleep_ff <= LIMIT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLEEP_MODE:  sleep_mode_ff  <= csr_wdata[0];
            CSR_LIMIT_AWAKE: limit_awake_ff <= csr_wdata;
            CSR_LIMIT_SLEEP: limit_sleep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shift/subtract unit: one quotient bit per cycle, MSB first
   assign dvs      = PROD_BITS'(wd_ff) << div_step_ff;
   assign dvs_fits = (rem_ff >= dvs);

   // datapath for the item in flight
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               item_ff <= req_data;
            end
         end
         ST_PREP: begin
            // counters wrap, so a plain modular subtract gives the interval
            wd_ff    <= item_ff.wall_total - prev_wall_ff[item_ff.core];
            id_ff    <= item_ff.idle_total - prev_idle_ff[item_ff.core];
            fetch_ff <= '0;
         end
         ST_FETCH: begin
            thr_ff[fetch_ff] <= table_ff[{item_ff.core, fetch_ff}];
            fetch_ff         <= fetch_ff + WSEL_BITS'(1);
         end
         ST_MULT: begin
            rem_ff      <= PROD_BITS'(wd_ff - id_ff) * PROD_BITS'(LOAD_SCALE);
            quo_ff      <= '0;
            div_step_ff <= 3'(LOAD_BITS - 1);
         end
         ST_DIV: begin
            if (dvs_fits) begin
               rem_ff               <= rem_ff - dvs;
               quo_ff[div_step_ff]  <= 1'b1;
            end
            div_step_ff <= div_step_ff - 3'd1;
         end
         default: ;
      endcase
   end

   // previous counters: refresh on every sample of the core
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORES; i++) begin
            prev_wall_ff[i] <= '0;
            prev_idle_ff[i] <= '0;
         end
      end else if (state_ff == ST_PREP) begin
         prev_wall_ff[item_ff.core] <= item_ff.wall_total;
         prev_idle_ff[item_ff.core] <= item_ff.idle_total;
      end
   end

   // threshold table, loaded with the default rows at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_ff[i] <= DEFAULT_WORDS[i];
         end
      end else if (decide_fire && (item_ff.cmd == CMD_WRITE)) begin
         table_ff[{item_ff.core, item_ff.word_select}] <= item_ff.word_value;
      end
   end

   // decision logic
   always_comb begin
      // a zero rate behaves as a rate of one
      up_period   = (thr_ff[W_UP_RATE] == '0) ? WORD_BITS'(1) : thr_ff[W_UP_RATE];
      down_period = (thr_ff[W_DOWN_RATE] == '0) ? WORD_BITS'(1) : thr_ff[W_DOWN_RATE];

      // restart a counter that ran past its rate
      up_eff   = (WORD_BITS'(up_cnt_ff[item_ff.core]) > up_period) ?
                 RATE_CNT_BITS'(1) : up_cnt_ff[item_ff.core];
      down_eff = (WORD_BITS'(down_cnt_ff[item_ff.core]) > down_period) ?
                 RATE_CNT_BITS'(1) : down_cnt_ff[item_ff.core];

      // counter never exceeds its rate here, so "mod rate == 0" is zero or equal
      chk_up   = (up_eff == '0) || (WORD_BITS'(up_eff) == up_period);
      chk_down = (down_eff == '0) || (WORD_BITS'(down_eff) == down_period);

      limit_sel = sleep_mode_ff ? limit_sleep_ff : limit_awake_ff;
      limit     = (limit_sel > LIMIT_BITS'(NUM_CORES)) ? LIMIT_BITS'(NUM_CORES) : limit_sel;
      next_core = LIMIT_BITS'(item_ff.core) + LIMIT_BITS'(1);

      qm         = QM_BITS'(item_ff.runnable) * QM_BITS'(QM_SCALE);
      load_valid = (wd_ff >= id_ff);

      up_cond = (next_core < limit)
             && (WORD_BITS'(quo_ff) >= thr_ff[W_UP_LOAD])
             && (item_ff.clock_khz >= thr_ff[W_UP_FREQ])
             && (WORD_BITS'(qm) > thr_ff[W_UP_RQ])
             && !item_ff.next_online;

      down_cond = (item_ff.core != '0)
               && ((item_ff.clock_khz <= thr_ff[W_DOWN_FREQ])
                   || ((WORD_BITS'(quo_ff) < thr_ff[W_DOWN_LOAD])
                       && (WORD_BITS'(qm) <= thr_ff[W_DOWN_RQ])));

      fire_up   = load_valid && up_cond && chk_up;
      fire_down = load_valid && !up_cond && down_cond && chk_down;

      up_new = up_eff;
      if (load_valid && up_cond) begin
         up_new = chk_up ? RATE_CNT_BITS'(1) : up_eff + RATE_CNT_BITS'(1);
      end
      down_new = down_eff;
      if (load_valid && !up_cond && down_cond) begin
         down_new = chk_down ? RATE_CNT_BITS'(1) : down_eff + RATE_CNT_BITS'(1);
      end
      up_next_set = fire_up && (next_core < LIMIT_BITS'(NUM_CORES));

      result = '0;
      if (item_ff.cmd == CMD_SAMPLE) begin
         result.request_up   = fire_up;
         result.request_down = fire_down;
         result.load_valid   = load_valid;
         result.load_pct     = load_valid ? quo_ff : '0;
         result.queue_metric = qm;
      end
   end

   // rate counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORES; i++) begin
            up_cnt_ff[i]   <= RATE_CNT_BITS'(1);
            down_cnt_ff[i] <= '0;
         end
      end else if (decide_fire && (item_ff.cmd == CMD_SAMPLE)) begin
         up_cnt_ff[item_ff.core]   <= up_new;
         down_cnt_ff[item_ff.core] <= down_new;
         if (up_next_set) begin
            up_cnt_ff[item_ff.core + CORE_BITS'(1)] <= RATE_CNT_BITS'(1);
         end
      end
   end

   // output register: load on decide, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decide_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_fire) begin
         rsp_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.request_up && rsp_data.request_down))
      else $error("up and down requested together");

   a_load_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.load_valid ? (rsp_data.load_pct <= 7'd100)
                                         : (rsp_data.load_pct == '0)))
      else $error("load out of range or set while invalid");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer ready right after accepting a word");

   a_request_needs_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.request_up || rsp_data.request_down)) |-> rsp_data.load_valid)
      else $error("request issued without a valid load");
`endif

endmodule

/* verif/hotplug_decision_checker.sv */
`timescale 1ns / 1ps

module hotplug_decision_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  hpd_pkg::req_type                     req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  hpd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [hpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                   mismatch_count,
   output int                                   outstanding,
   output int                                   ups_seen,
   output int                                   downs_seen,
   output int                                   skipped_loads
);
   import hpd_pkg::*;

   // shadow copy of the block's state and configuration
   logic                     sleep_mode;
   logic [LIMIT_BITS-1:0]    limit_awake;
   logic [LIMIT_BITS-1:0]    limit_sleep;
   logic [TOTAL_BITS-1:0]    prev_wall [NUM_CORES];
   logic [TOTAL_BITS-1:0]    prev_idle [NUM_CORES];
   logic [RATE_CNT_BITS-1:0] up_cnt    [NUM_CORES];
   logic [RATE_CNT_BITS-1:0] down_cnt  [NUM_CORES];
   logic [WORD_BITS-1:0]     thr       [TABLE_DEPTH];

   rsp_type pending_decisions [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      ups_seen       = 0;
      downs_seen     = 0;
      skipped_loads  = 0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advance the shadow state by one word and return the response it should produce.
   function automatic rsp_type decide_hotplug(input req_type w);
      rsp_type     r;
      int unsigned c, base, up_period, down_period, lim, nxt, wd, id, load, qm;
      logic [63:0] prod;
      logic        chk_up, chk_down;
      r    = '0;
      c    = w.core;
      base = c * WORDS_PER_CORE;
      if (w.cmd == CMD_WRITE) begin
         thr[base + w.word_select] = w.word_value;
         return r;
      end
      up_period   = (thr[base + W_UP_RATE] == 0) ? 1 : thr[base + W_UP_RATE];
      down_period = (thr[base + W_DOWN_RATE] == 0) ? 1 : thr[base + W_DOWN_RATE];
      lim = sleep_mode ? limit_sleep : limit_awake;
      if (lim > NUM_CORES) lim = NUM_CORES;
      if (up_cnt[c] > up_period) up_cnt[c] = 1;
      if (down_cnt[c] > down_period) down_cnt[c] = 1;
      chk_up   = (up_cnt[c] % up_period) == 0;
      chk_down = (down_cnt[c] % down_period) == 0;

      qm = w.runnable * QM_SCALE;
      wd = w.wall_total - prev_wall[c];
      id = w.idle_total - prev_idle[c];
      prev_wall[c] = w.wall_total;
      prev_idle[c] = w.idle_total;
      load = 0;
      nxt  = c + 1;

      if (wd >= id) begin
         r.load_valid = 1'b1;
         if (wd > id) begin
            prod = 64'(wd - id) * 64'(LOAD_SCALE);
            load = int'(prod / 64'(wd));
         end
         if (nxt < lim && load >= thr[base + W_UP_LOAD] &&
             w.clock_khz >= thr[base + W_UP_FREQ] && qm > thr[base + W_UP_RQ] &&
             !w.next_online) begin
            if (chk_up) begin
               r.request_up = 1'b1;
               up_cnt[c] = 1;
               if (nxt < NUM_CORES) up_cnt[nxt] = 1;
            end else begin
               up_cnt[c] = up_cnt[c] + 1'b1;
            end
         end else if (c > 0) begin
            if (w.clock_khz <= thr[base + W_DOWN_FREQ] ||
                (load < thr[base + W_DOWN_LOAD] && qm <= thr[base + W_DOWN_RQ])) begin
               if (chk_down) begin
                  r.request_down = 1'b1;
                  down_cnt[c] = 1;
               end else begin
                  down_cnt[c] = down_cnt[c] + 1'b1;
               end
            end
         end
      end else begin
         skipped_loads++;
      end
      r.load_pct     = load[LOAD_BITS-1:0];
      r.queue_metric = qm[QM_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pending_decisions.delete();
         sleep_mode  = 1'b0;
         limit_awake = 3'd4;
         limit_sleep = 3'd1;
         for (int i = 0; i < NUM_CORES; i++) begin
            prev_wall[i] = '0;
            prev_idle[i] = '0;
            up_cnt[i]    = 1;
            down_cnt[i]  = 0;
         end
         for (int i = 0; i < TABLE_DEPTH; i++) thr[i] = DEFAULT_WORDS[i];
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SLEEP_MODE:  sleep_mode  = csr_wdata[0];
               CSR_LIMIT_AWAKE: limit_awake = csr_wdata;
               CSR_LIMIT_SLEEP: limit_sleep = csr_wdata;
               default: ;
            endcase
         end
         // retire the response before queuing a new word
         if (rsp_valid && rsp_ready) begin
            if (pending_decisions.size() == 0) begin
               report_mismatch("response with nothing expected", 1, 0);
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_data.request_up != want.request_up)
                  report_mismatch("request_up", rsp_data.request_up, want.request_up);
               if (rsp_data.request_down != want.request_down)
                  report_mismatch("request_down", rsp_data.request_down, want.request_down);
               if (rsp_data.load_valid != want.load_valid)
                  report_mismatch("load_valid", rsp_data.load_valid, want.load_valid);
               if (rsp_data.load_pct != want.load_pct)
                  report_mismatch("load_pct", rsp_data.load_pct, want.load_pct);
               if (rsp_data.queue_metric != want.queue_metric)
                  report_mismatch("queue_metric", rsp_data.queue_metric, want.queue_metric);
               if (want.request_up) ups_seen++;
               if (want.request_down) downs_seen++;
            end
         end
         if (req_valid && req_ready) pending_decisions.push_back(decide_hotplug(req_data));
      end
      outstanding <= pending_decisions.size();
   end

endmodule

/* verif/tb_core_hotplug_decider.sv */
`timescale 1ns / 1ps

module tb_core_hotplug_decider;
   import hpd_pkg::*;

   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int SETTLE_CYCLES   = 24;
   localparam int DRAIN_LIMIT     = 4000;
   localparam int WATCHDOG_NS     = 10_000_000;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int mismatch_count, outstanding, ups_seen, downs_seen, skipped_loads;

   // stimulus-side copy of each core's running counters
   logic [TOTAL_BITS-1:0] cur_wall [NUM_CORES] = '{default: '0};
   logic [TOTAL_BITS-1:0] cur_idle [NUM_CORES] = '{default: '0};

   // clock points around every default frequency threshold, plus the extremes
   int unsigned freq_pts [8] = '{0, 810000, 918000, 1026000, 1242000, 1566000,
                                 1674000, 24'hFF_FFFF};

   // register settings per phase; limits include 0 and saturating values
   logic [CSR_DATA_BITS-1:0] sleep_set [NUM_PHASES] = '{0, 1, 0, 0, 1, 1};
   logic [CSR_DATA_BITS-1:0] awake_set [NUM_PHASES] = '{4, 2, 1, 7, 0, 3};
   logic [CSR_DATA_BITS-1:0] slp_set   [NUM_PHASES] = '{1, 4, 3, 6, 0, 7};

   bit throttle = 1'b1;
   int rsp_hold = 0;
   int n_samples = 0;
   int n_writes  = 0;

   core_hotplug_decider u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hotplug_decision_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .ups_seen       (ups_seen),
      .downs_seen     (downs_seen),
      .skipped_loads  (skipped_loads)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Pick an idle stretch: mostly short, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Stall the response side at random while throttling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         if (throttle && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   // Present one word and hold it until accepted. Called at a clock edge; on return
   // the word has just been taken and valid is still high, so a following call can
   // place the next word back to back.
   task automatic send_word(input req_type w);
      int gap;
      gap = (throttle && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Build a sample word; fill the table-write fields with noise.
   task automatic send_sample(input int unsigned c, input logic [31:0] wall,
                              input logic [31:0] idle, input logic [23:0] clk,
                              input logic [7:0] run, input logic nxt);
      req_type w;
      w.cmd         = CMD_SAMPLE;
      w.core        = c[CORE_BITS-1:0];
      w.wall_total  = wall;
      w.idle_total  = idle;
      w.clock_khz   = clk;
      w.runnable    = run;
      w.next_online = nxt;
      w.word_select = $urandom_range(0, 7);
      w.word_value  = $urandom_range(0, 24'hFF_FFFF);
      cur_wall[c]   = wall;
      cur_idle[c]   = idle;
      n_samples++;
      send_word(w);
   endtask

   // Build a threshold write; fill the sample fields with noise.
   task automatic send_write(input int unsigned c, input logic [WSEL_BITS-1:0] sel,
                             input logic [WORD_BITS-1:0] val);
      req_type w;
      w.cmd         = CMD_WRITE;
      w.core        = c[CORE_BITS-1:0];
      w.wall_total  = $urandom();
      w.idle_total  = $urandom();
      w.clock_khz   = $urandom_range(0, 24'hFF_FFFF);
      w.runnable    = $urandom_range(0, 255);
      w.next_online = $urandom_range(0, 1);
      w.word_select = sel;
      w.word_value  = val;
      n_writes++;
      send_word(w);
   endtask

   // Drop valid, wait for every expected response, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < DRAIN_LIMIT && outstanding != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned           c, kind, dw, busy, pick;
      logic [TOTAL_BITS-1:0] wall, idle;
      logic [23:0]           clk;
      logic [7:0]            run;
      logic [WSEL_BITS-1:0]  sel;
      logic [WORD_BITS-1:0]  val;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed words under the reset configuration ----
      send_sample(0, 0, 0, 1242000, 2, 0);                 // zero deltas: load 0
      send_sample(0, 1000, 0, 1242000, 2, 0);              // full load: bring core 1 up
      send_sample(0, 2000, 1000, 1241999, 2, 0);           // clock just below up freq
      send_sample(1, 100, 200, 1566000, 5, 0);             // idle above wall: skip
      send_sample(1, 300, 400, 810000, 0, 0);              // equal deltas, clock at down freq
      send_sample(1, 1300, 400, 1566000, 3, 0);            // up held off by rate counter
      send_sample(1, 2300, 400, 1566000, 3, 0);            // rate counter now lets up fire
      send_sample(2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 255, 1); // next already up
      send_sample(2, 32'h0000_0100, 32'h8000_0000, 1674000, 4, 0);       // counters wrap
      send_sample(3, 5000, 4000, 0, 0, 0);                 // last core, zero clock
      send_sample(3, 9000, 4000, 1026001, 255, 0);         // last core never goes up
      send_sample(3, 9100, 4099, 1026001, 2, 0);           // low load, low queue: down held off by rate counter
      send_write(1, W_UP_RATE, 0);                         // zero rate reads as one
      send_sample(1, 3300, 400, 1566000, 3, 0);
      send_write(2, W_DOWN_RATE, 0);
      send_write(0, W_UP_LOAD, 24'hFF_FFFF);
      send_write(2, W_DOWN_LOAD, 101);
      send_write(3, W_UP_FREQ, 0);
      send_write(3, W_DOWN_FREQ, 24'hFF_FFFF);
      send_write(2, W_UP_RQ, 0);
      send_write(1, W_DOWN_RQ, 25500);
      send_sample(2, 32'h0000_0200, 32'h8000_0000, 0, 0, 0);
      send_write(0, W_UP_LOAD, 60);

      // ---- random phases, one register setting each ----
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         csr_we    <= 1'b1;
         csr_index <= CSR_SLEEP_MODE;
         csr_wdata <= sleep_set[p];
         @(posedge clock);
         csr_index <= CSR_LIMIT_AWAKE;
         csr_wdata <= awake_set[p];
         @(posedge clock);
         csr_index <= CSR_LIMIT_SLEEP;
         csr_wdata <= slp_set[p];
         @(posedge clock);
         csr_we <= 1'b0;
         // run two phases flat out on both sides
         throttle = (p != 1 && p != 4);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            c = $urandom_range(0, NUM_CORES - 1);
            if ($urandom_range(0, 9) == 0) begin
               // sensible thresholds mostly, so decisions keep firing
               sel = $urandom_range(0, 7);
               case (sel)
                  W_UP_LOAD, W_DOWN_LOAD: val = $urandom_range(0, 101);
                  W_UP_FREQ, W_DOWN_FREQ: val = freq_pts[$urandom_range(0, 7)];
                  W_UP_RQ, W_DOWN_RQ:     val = 100 * $urandom_range(0, 6);
                  default:
                     // last phase: rates near and past the 4-bit counter range to force wrap
                     val = (p == NUM_PHASES - 1) ? $urandom_range(12, 20)
                                                 : $urandom_range(0, 5);
               endcase
               if ($urandom_range(0, 19) == 0) val = $urandom_range(0, 24'hFF_FFFF);
               send_write(c, sel, val);
            end else begin
               kind = $urandom_range(0, 99);
               dw   = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 200000);
               if (kind < 70) begin
                  // well-formed interval: full, idle or any load in between
                  pick = $urandom_range(0, 3);
                  busy = (pick == 0) ? dw : (pick == 1) ? 0 : $urandom_range(0, dw);
                  wall = cur_wall[c] + dw;
                  idle = cur_idle[c] + (dw - busy);
               end else if (kind < 80) begin
                  wall = cur_wall[c] + dw;
                  idle = cur_idle[c] + dw + $urandom_range(1, 5000);
               end else if (kind < 85) begin
                  if (kind < 82) dw = 0;
                  wall = cur_wall[c] + dw;
                  idle = cur_idle[c] + dw;
               end else begin
                  wall = $urandom();
                  idle = $urandom();
               end
               if ($urandom_range(0, 3) == 0) clk = $urandom_range(0, 24'hFF_FFFF);
               else clk = freq_pts[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
               run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 6);
               send_sample(c, wall, idle, clk, run, $urandom_range(0, 3) == 0);
            end
         end
      end

      wait_idle();
      $display("Covered %0d samples and %0d threshold writes over %0d register settings",
               n_samples, n_writes, NUM_PHASES + 1);
      $display("Decisions: %0d up, %0d down, %0d skipped loads",
               ups_seen, downs_seen, skipped_loads);
      if (outstanding != 0) $display("%0d responses never arrived", outstanding);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Kill a hung run.
   initial begin
      #(WATCHDOG_NS);
      $display("watchdog expired with %0d responses outstanding", outstanding);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
